@@ rtl/iss_pkg.sv @@
// Shared types and constants of the indexed sequence store.
`default_nettype none
package iss_pkg;
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_SORT    = 3'd5;
  localparam logic [2:0] OP_REVERSE = 3'd6;
  localparam logic [2:0] OP_LENGTH  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_HIGH  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Datapath address-register selects.
  typedef enum logic [2:0] {
    A_HOLD  = 3'd0,
    A_LOAD  = 3'd1,  // a <= b
    A_DEC   = 3'd2,
    A_INC   = 3'd3,
    A_POS   = 3'd4,
    A_ZERO  = 3'd5,
    A_COUNT = 3'd6,
    A_CNTM1 = 3'd7
  } asel_t;

  typedef struct packed {
    asel_t      ia_sel;     // address register i
    asel_t      jb_sel;     // address register j (A_LOAD: j <= i)
    logic       rd_i;       // read address: 1 = i, 0 = j
    logic       wr_en;
    logic       wr_i;       // write address: 1 = i, 0 = j
    logic [1:0] wr_src;     // 0 item value, 1 read data, 2 held value v, 3 held t
    logic       ld_v;       // v <= read data
    logic       ld_t;       // t <= read data
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       ld_res;     // capture result
    logic       res_rd;     // result carries read data
  } iss_cmd_t;

  typedef struct packed {
    logic i_gt_pos;     // i > pos
    logic i1_lt_cnt;    // i + 1 < count
    logic j_zero;
    logic i_lt_j;
    logic rd_gt_v;      // read data > v as signed
    logic cnt_zero;
    logic cnt_full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic cnt_lt2;
  } iss_sts_t;
endpackage
`default_nettype wire

@@ rtl/iss_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/iss_datapath.sv @@
// Datapath: element memory, address registers, count and result registers.
`default_nettype none
module iss_datapath import iss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_take,
  input  wire signed [31:0] in_val,
  input  wire [5:0]         in_pos,
  input  iss_cmd_t          cmd,
  input  wire [1:0]         res_st,
  output iss_sts_t          sts,
  output logic [31:0]       res_value,
  output logic [6:0]        res_length,
  output logic [1:0]        res_status
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = ($clog2(DEPTH + 1) > 7) ? $clog2(DEPTH + 1) : 7;
  // Address registers hold DEPTH as well as any position without truncation.
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, cnt_r;
  logic [CW-1:0] pos_r;
  logic [31:0]   val_r, v_r, t_r, rdata, wdata;
  logic [CW-1:0] pos_ext;

  assign pos_ext = CW'(in_pos);

  function automatic logic [CW-1:0] nxt_addr(asel_t s, logic [CW-1:0] cur,
      logic [CW-1:0] other, logic [CW-1:0] p, logic [CW-1:0] c);
    case (s)
      A_HOLD:  return cur;
      A_LOAD:  return other;
      A_DEC:   return cur - CW'(1);
      A_INC:   return cur + CW'(1);
      A_POS:   return p;
      A_ZERO:  return '0;
      A_COUNT: return c;
      A_CNTM1: return c - CW'(1);
      default: return cur;
    endcase
  endfunction

  assign i_nxt = nxt_addr(cmd.ia_sel, i_r, j_r, pos_r, cnt_r);
  assign j_nxt = nxt_addr(cmd.jb_sel, j_r, i_r, pos_r, cnt_r);

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (in_take) begin
      val_r <= in_val;
      pos_r <= pos_ext;
    end
    if (cmd.ld_v) v_r <= rdata;
    if (cmd.ld_t) t_r <= rdata;
    if (cmd.ld_res) begin
      res_value  <= cmd.res_rd ? rdata : 32'd0;
      res_length <= 7'(cnt_r);
      res_status <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_comb begin
    case (cmd.wr_src)
      2'd0:    wdata = val_r;
      2'd1:    wdata = rdata;
      2'd2:    wdata = v_r;
      default: wdata = t_r;
    endcase
  end

  iss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(cmd.wr_i ? i_r[AW-1:0] : j_r[AW-1:0]),
    .wdata(wdata),
    .raddr(cmd.rd_i ? i_r[AW-1:0] : j_r[AW-1:0]),
    .rdata(rdata)
  );

  assign sts.i_gt_pos   = i_r > pos_r;
  assign sts.i1_lt_cnt  = (i_r + CW'(1)) < cnt_r;
  assign sts.j_zero     = j_r == '0;
  assign sts.i_lt_j     = i_r < j_r;
  assign sts.rd_gt_v    = $signed(rdata) > $signed(v_r);
  assign sts.cnt_zero   = cnt_r == '0;
  assign sts.cnt_full   = cnt_r >= CW'(DEPTH);
  assign sts.pos_gt_cnt = pos_r > cnt_r;
  assign sts.pos_ge_cnt = pos_r >= cnt_r;
  assign sts.cnt_lt2    = cnt_r < CW'(2);
endmodule
`default_nettype wire

@@ rtl/iss_ctrl.sv @@
// Controller: sequences every operation and its accesses to the element memory.
`default_nettype none
module iss_ctrl import iss_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_take,
  input  wire [2:0]  in_kind,
  input  iss_sts_t   sts,
  input  wire        out_free,
  output logic       busy,
  output logic       res_done,
  output iss_cmd_t   cmd,
  output logic [1:0] res_st
);
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DISP   = 14'b00000000000010,
    S_SHUP   = 14'b00000000000100,  // insert: read i-1
    S_SHUPW  = 14'b00000000001000,  // shift: read issued, or append write
    S_SHDN   = 14'b00000000010000,  // remove: read i+1
    S_SHDNW  = 14'b00000000100000,
    S_RDW    = 14'b00000001000000,  // read: issue read at pos
    S_SRTV   = 14'b00000010000000,  // sort: next outer index
    S_SRTR   = 14'b00000100000000,  // sort: read e[i]
    S_SRTC   = 14'b00001000000000,  // sort: compare / shift
    S_SRTW   = 14'b00010000000000,  // sort: write the hole
    S_REVA   = 14'b00100000000000,  // reverse: read lo, then hi
    S_REVB   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r;
  logic [1:0] st_r, st_nxt;
  logic [1:0] rev_ph_r, rev_ph_nxt;

  assign busy   = state_r != S_IDLE;
  assign res_st = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      st_r     <= ST_OK;
      rev_ph_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      st_r     <= st_nxt;
      rev_ph_r <= rev_ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) kind_r <= in_kind;
  end

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    rev_ph_nxt = rev_ph_r;
    res_done   = 1'b0;
    cmd        = '0;
    cmd.rd_i   = 1'b1;
    cmd.wr_i   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_DISP;
      end
      S_DISP: begin
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
        case (kind_r)
          OP_APPEND: begin
            if (sts.cnt_full) st_nxt = ST_FULL;
            else begin
              cmd.ia_sel = A_COUNT;
              state_nxt  = S_SHUPW;  // writes item at i = count
            end
          end
          OP_INSERT: begin
            if (sts.pos_gt_cnt) st_nxt = ST_HIGH;
            else if (sts.cnt_full) st_nxt = ST_FULL;
            else begin
              cmd.ia_sel = A_COUNT;
              state_nxt  = S_SHUP;
            end
          end
          OP_READ: begin
            if (sts.cnt_zero) st_nxt = ST_EMPTY;
            else if (sts.pos_ge_cnt) st_nxt = ST_HIGH;
            else begin
              cmd.ia_sel = A_POS;
              state_nxt  = S_RDW;
            end
          end
          OP_REMOVE: begin
            if (sts.cnt_zero) st_nxt = ST_EMPTY;
            else if (sts.pos_ge_cnt) st_nxt = ST_HIGH;
            else begin
              cmd.ia_sel = A_POS;
              state_nxt  = S_SHDN;
            end
          end
          OP_CLEAR: cmd.cnt_clr = 1'b1;
          OP_SORT: begin
            if (!sts.cnt_lt2) begin
              cmd.ia_sel = A_ZERO;
              rev_ph_nxt = 2'd0;
              state_nxt  = S_SRTV;
            end
          end
          OP_REVERSE: begin
            if (!sts.cnt_lt2) begin
              cmd.ia_sel = A_ZERO;
              cmd.jb_sel = A_CNTM1;
              rev_ph_nxt = 2'd0;
              state_nxt  = S_REVA;
            end
          end
          default: ;
        endcase
      end
      S_SHUP: begin
        // Shift e[i-1] to e[i] while i > pos, then drop the item in.
        if (sts.i_gt_pos) begin
          cmd.jb_sel = A_LOAD;
          cmd.ia_sel = A_DEC;   // read address uses i-1 next cycle
          state_nxt  = S_SHUPW;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = 2'd0;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_SHUPW: begin
        if (kind_r == OP_APPEND) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = 2'd0;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          // The read of e[i] issued this cycle; j holds the old i.
          state_nxt = S_SHDNW;
        end
      end
      S_SHDN: begin
        // Remove: move e[i+1] to e[i] while i+1 < count.
        if (sts.i1_lt_cnt) begin
          cmd.jb_sel = A_LOAD;
          cmd.ia_sel = A_INC;
          state_nxt  = S_SHUPW;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_SHDNW: begin
        // Read data at i is valid; write it to j.
        cmd.wr_en  = 1'b1;
        cmd.wr_i   = 1'b0;
        cmd.wr_src = 2'd1;
        state_nxt  = (kind_r == OP_INSERT) ? S_SHUP : S_SHDN;
      end
      S_RDW: begin
        // The read of e[pos] is issued here; its data is valid in S_DONE.
        state_nxt = S_DONE;
      end
      S_SRTV: begin
        // Outer loop: i runs from 1; i starts at 0 and increments here.
        cmd.ia_sel = A_INC;
        cmd.jb_sel = A_LOAD;
        if (!sts.i1_lt_cnt) begin
          cmd.ia_sel = A_HOLD;
          cmd.jb_sel = A_HOLD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SRTR;
        end
      end
      S_SRTR: begin
        // Read e[i] and start with the hole at j = i.
        cmd.jb_sel = A_LOAD;
        state_nxt  = S_SRTC;
      end
      S_SRTC: begin
        cmd.rd_i = 1'b0;
        case (rev_ph_r)
          2'd0: begin
            // e[i] arrives; step j below the hole.
            cmd.ld_v   = 1'b1;
            cmd.jb_sel = A_DEC;
            rev_ph_nxt = 2'd2;
          end
          2'd1: begin
            // j is the hole after a shift.
            if (sts.j_zero) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_i   = 1'b0;
              cmd.wr_src = 2'd2;
              rev_ph_nxt = 2'd0;
              state_nxt  = S_SRTV;
            end else begin
              cmd.jb_sel = A_DEC;
              rev_ph_nxt = 2'd2;
            end
          end
          2'd2: rev_ph_nxt = 2'd3;  // read of e[j] in flight
          default: begin
            // e[j] is valid and the hole is j + 1.
            cmd.jb_sel = A_INC;
            state_nxt  = S_SRTW;
            if (sts.rd_gt_v) begin
              cmd.ld_t   = 1'b1;
              rev_ph_nxt = 2'd1;
            end else begin
              rev_ph_nxt = 2'd0;
            end
          end
        endcase
      end
      S_SRTW: begin
        // Phase 1 moves the larger element up; phase 0 places v.
        cmd.wr_en = 1'b1;
        cmd.wr_i  = 1'b0;
        if (rev_ph_r == 2'd1) begin
          cmd.wr_src = 2'd3;
          cmd.jb_sel = A_DEC;
          state_nxt  = S_SRTC;
        end else begin
          cmd.wr_src = 2'd2;
          state_nxt  = S_SRTV;
        end
      end
      S_REVA: begin
        // Phase 0 reads lo, 1 holds it and reads hi, 2 waits, 3 writes lo.
        case (rev_ph_r)
          2'd0: begin
            if (!sts.i_lt_j) state_nxt = S_DONE;
            else rev_ph_nxt = 2'd1;
          end
          2'd1: begin
            cmd.ld_t   = 1'b1;
            cmd.rd_i   = 1'b0;
            rev_ph_nxt = 2'd2;
          end
          2'd2: begin
            cmd.rd_i   = 1'b0;
            rev_ph_nxt = 2'd3;
          end
          default: begin
            cmd.wr_en  = 1'b1;   // e[lo] <= e[hi]
            cmd.wr_src = 2'd1;
            state_nxt  = S_REVB;
          end
        endcase
      end
      S_REVB: begin
        cmd.wr_en  = 1'b1;       // e[hi] <= old e[lo]
        cmd.wr_i   = 1'b0;
        cmd.wr_src = 2'd3;
        cmd.ia_sel = A_INC;
        cmd.jb_sel = A_DEC;
        rev_ph_nxt = 2'd0;
        state_nxt  = S_REVA;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.ld_res = 1'b1;
          cmd.res_rd = (kind_r == OP_READ) && (st_r == ST_OK);
          res_done   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/indexed_sequence_store_unit.sv @@
// Top level of the indexed sequence store.
// One operation is taken at a time and answered with exactly one result.
// Length, clear and the failing checks do not touch the memory. Insert and
// remove move one element at a time, reverse swaps one pair at a time, and
// sort runs an insertion sort. A result that is not yet taken holds the next
// one back in its final state. All element traffic goes through one memory
// with one read and one write port and registered read data. No clearing
// pass is needed after reset.
`default_nettype none
module indexed_sequence_store_unit import iss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tuser,   // [2:0] kind
  input  wire  [39:0] in_tdata,   // [31:0] item_value, [37:32] position
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // [31:0] read_value, [38:32] length, [40:39] status
);
  iss_cmd_t    cmd;
  iss_sts_t    sts;
  logic        busy, res_done, take, out_valid_r;
  logic [1:0]  res_st, res_status;
  logic [31:0] res_value;
  logic [6:0]  res_length;

  assign in_tready = !busy;
  assign take      = in_tvalid && in_tready;

  iss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_take(take), .in_kind(in_tuser[2:0]),
    .sts(sts), .out_free(!out_valid_r || out_tready), .busy(busy),
    .res_done(res_done), .cmd(cmd), .res_st(res_st)
  );

  iss_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_take(take),
    .in_val(in_tdata[31:0]), .in_pos(in_tdata[37:32]), .cmd(cmd),
    .res_st(res_st), .sts(sts), .res_value(res_value),
    .res_length(res_length), .res_status(res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_status, res_length, res_value};

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !take) else $error("item taken while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !res_done) else $error("result without work");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_length <= 7'(DEPTH)) else $error("length above depth");
endmodule
`default_nettype wire

@@ bench/iss_checker.sv @@
// Checker for the indexed sequence store: predicts each result and compares it.
`timescale 1ns / 1ps
module iss_checker import iss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [7:0]  in_tuser,
  input  wire  [39:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [47:0] out_tdata,
  output int          error_count,
  output int          pending_count,
  output int          stored_count
);
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [6:0]         length;
    logic [1:0]         status;
  } iss_result_t;

  logic signed [31:0] seq_model [DEPTH];
  int unsigned seq_len;
  iss_result_t result_queue [$];

  assign stored_count = seq_len;

  function automatic iss_result_t apply_operation(logic [2:0] kind, logic signed [31:0] value,
                                                  int unsigned pos);
    iss_result_t res;
    logic signed [31:0] hold;
    int i;
    int j;
    res = '0;
    res.status = ST_OK;
    case (kind)
      OP_APPEND: begin
        if (seq_len >= DEPTH) res.status = ST_FULL;
        else begin
          seq_model[seq_len] = value;
          seq_len++;
        end
      end
      OP_INSERT: begin
        if (pos > seq_len) res.status = ST_HIGH;
        else if (seq_len >= DEPTH) res.status = ST_FULL;
        else begin
          for (i = seq_len; i > pos; i--) seq_model[i] = seq_model[i-1];
          seq_model[pos] = value;
          seq_len++;
        end
      end
      OP_READ: begin
        if (seq_len == 0) res.status = ST_EMPTY;
        else if (pos >= seq_len) res.status = ST_HIGH;
        else res.read_value = seq_model[pos];
      end
      OP_REMOVE: begin
        if (seq_len == 0) res.status = ST_EMPTY;
        else if (pos >= seq_len) res.status = ST_HIGH;
        else begin
          for (i = pos; i + 1 < seq_len; i++) seq_model[i] = seq_model[i+1];
          seq_len--;
        end
      end
      OP_CLEAR: seq_len = 0;
      OP_SORT: begin
        for (i = 1; i < seq_len; i++) begin
          hold = seq_model[i];
          j = i;
          while (j > 0 && seq_model[j-1] > hold) begin
            seq_model[j] = seq_model[j-1];
            j--;
          end
          seq_model[j] = hold;
        end
      end
      OP_REVERSE: begin
        j = int'(seq_len) - 1;
        for (i = 0; i < j; i++) begin
          hold = seq_model[i];
          seq_model[i] = seq_model[j];
          seq_model[j] = hold;
          j--;
        end
      end
      default: ;
    endcase
    res.length = seq_len[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    iss_result_t want;
    iss_result_t got;
    if (!rst_n) begin
      seq_len = 0;
      error_count <= 0;
      result_queue.delete();
      pending_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        result_queue.push_back(apply_operation(in_tuser[2:0], in_tdata[31:0], in_tdata[37:32]));
      if (out_tvalid && out_tready) begin
        got.read_value = out_tdata[31:0];
        got.length = out_tdata[38:32];
        got.status = out_tdata[40:39];
        if (result_queue.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10) $display("unexpected result transaction %h", out_tdata);
        end else begin
          want = result_queue.pop_front();
          if (want != got) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("mismatch: expected value %0d length %0d status %0d, got %0d %0d %0d",
                       want.read_value, want.length, want.status,
                       got.read_value, got.length, got.status);
          end
        end
      end
      pending_count = result_queue.size();
    end
  end
endmodule

@@ bench/testbench.sv @@
// Top of the indexed sequence store bench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module testbench;
  import iss_pkg::*;
  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  int          error_count;
  int          pending_count;
  int          stored_count;
  int          cycle_count = 0;
  bit          calm = 0;

  always #4 clk = ~clk;

  indexed_sequence_store_unit #(.DEPTH(DEPTH)) dut (.*);

  iss_checker #(.DEPTH(DEPTH)) checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stalls in random bursts until the calm phase.
  always @(posedge clk) begin
    int stall;
    if (!calm && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 4);
      out_tready <= 0;
      repeat (stall) @(posedge clk);
    end
    out_tready <= 1;
  end

  // The valid stays high after an accepted transaction until the next one
  // replaces it; the block is busy in the cycle after any accept.
  task automatic send_op(logic [2:0] kind, logic [31:0] value, logic [5:0] pos);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= {5'd0, kind};
    in_tdata <= {2'd0, pos, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Mostly legal positions, sometimes any 6-bit value.
  function automatic logic [5:0] pick_position(bit wide);
    if (wide || $urandom_range(0, 7) == 0) return 6'($urandom);
    return 6'($urandom_range(0, stored_count));
  endfunction

  initial begin
    int n;
    int w;
    logic [2:0] kind;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: empty-store errors, extremes, full store, all operations.
    send_op(OP_READ, 0, 0);
    send_op(OP_REMOVE, 0, 0);
    send_op(OP_SORT, 0, 0);
    send_op(OP_REVERSE, 0, 0);
    send_op(OP_INSERT, 32'h7fffffff, 6'd1);
    send_op(OP_INSERT, 32'h80000000, 6'd0);
    send_op(OP_APPEND, 32'hffffffff, 0);
    send_op(OP_INSERT, 32'h00000001, 6'd3);
    send_op(OP_READ, 0, 6'd3);
    send_op(OP_READ, 0, 6'd63);
    send_op(OP_REVERSE, 0, 0);
    send_op(OP_SORT, 0, 0);
    send_op(OP_READ, 0, 6'd0);
    send_op(OP_REMOVE, 0, 6'd3);
    send_op(OP_REMOVE, 0, 6'd0);
    send_op(OP_LENGTH, 0, 6'd5);
    while (stored_count < DEPTH) send_op(OP_APPEND, $urandom, 0);
    send_op(OP_APPEND, 1, 0);
    send_op(OP_INSERT, 2, 6'd10);
    send_op(OP_SORT, 0, 0);
    send_op(OP_READ, 0, 6'd63);
    send_op(OP_REMOVE, 0, 6'd63);
    send_op(OP_CLEAR, 0, 0);
    // Wait for every outstanding result before the random phase.
    drain();
    for (n = 0; n < 1200; n++) begin
      if (n == 1000) calm = 1;
      w = $urandom_range(0, 99);
      if (w < 30) kind = OP_APPEND;
      else if (w < 45) kind = OP_INSERT;
      else if (w < 62) kind = OP_READ;
      else if (w < 77) kind = OP_REMOVE;
      else if (w < 80) kind = (stored_count > 40) ? OP_CLEAR : OP_LENGTH;
      else if (w < 86) kind = OP_SORT;
      else if (w < 93) kind = OP_REVERSE;
      else kind = 3'($urandom);
      send_op(kind, (w & 1) ? $urandom : 32'($signed($urandom_range(0, 20)) - 10),
              pick_position(w < 5));
    end
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/iss_pkg.sv
rtl/iss_ram.sv
rtl/iss_datapath.sv
rtl/iss_ctrl.sv
rtl/indexed_sequence_store_unit.sv
bench/iss_checker.sv
bench/testbench.sv
